// File: rtl/gp3rot_pkg.sv
// Shared types, constants and rounding function for the grid point rotation core.
`default_nettype none

package gp3rot_pkg;

	// Fixed-point formats
	localparam int unsigned TRIG_FRAC_BITS = 14;
	localparam int unsigned GAIN_FRAC_BITS = 8;

	// Field and register widths
	localparam int unsigned OFS_IN_W = 12;
	localparam int unsigned HGT_IN_W = 16;
	localparam int unsigned TRIG_W   = 16;
	localparam int unsigned ZOOM_W   = 8;
	localparam int unsigned GAIN_W   = 17;
	localparam int unsigned COORD_W  = 32;

	// Scaled offsets: 2048 * 255 stays below 2^19, so 20 bits signed hold them
	localparam int unsigned OFS_W = OFS_IN_W + ZOOM_W;
	localparam int unsigned HGT_W = HGT_IN_W + GAIN_W;

	// First rotation (about x): products and sums
	localparam int unsigned BT_P_W = OFS_W + TRIG_W;
	localparam int unsigned HT_P_W = HGT_W + TRIG_W;
	localparam int unsigned RX_S_W =
		((BT_P_W + GAIN_FRAC_BITS) > HT_P_W ? (BT_P_W + GAIN_FRAC_BITS) : HT_P_W) + 1;
	localparam int unsigned RX_FRAC = TRIG_FRAC_BITS + GAIN_FRAC_BITS;

	// Second and third rotations: coordinate times trig value
	localparam int unsigned AT_P_W = OFS_W + TRIG_W;
	localparam int unsigned CT_P_W = COORD_W + TRIG_W;
	localparam int unsigned RYZ_S_W = CT_P_W + 1;

	// Round-function operand width
	localparam int unsigned RND_W = 64;

	// APB address and data
	localparam int unsigned PADDR_W = 5;
	localparam int unsigned PDATA_W = 32;

	// Register map
	typedef enum logic [2:0] {
		REG_COS_X = 3'd0,
		REG_SIN_X = 3'd1,
		REG_COS_Y = 3'd2,
		REG_SIN_Y = 3'd3,
		REG_COS_Z = 3'd4,
		REG_SIN_Z = 3'd5,
		REG_ZOOM  = 3'd6,
		REG_GAIN  = 3'd7
	} reg_idx_t;

	// Register reset values
	localparam logic signed [TRIG_W-1:0] TRIG_ONE   = TRIG_W'(1 << TRIG_FRAC_BITS);
	localparam logic signed [TRIG_W-1:0] TRIG_ZERO  = '0;
	localparam logic [ZOOM_W-1:0]        ZOOM_RESET = ZOOM_W'(1);
	localparam logic signed [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1 << GAIN_FRAC_BITS);

	// Request payloads
	typedef struct packed {
		logic signed [OFS_IN_W-1:0] column_offset;
		logic signed [OFS_IN_W-1:0] row_offset;
		logic signed [HGT_IN_W-1:0] point_height;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] rotated_x;
		logic signed [COORD_W-1:0] rotated_y;
		logic signed [COORD_W-1:0] rotated_z;
	} result_t;

	// Round half away from zero with f fraction bits, then clamp to 32 bits signed.
	// For negatives, (v + half - 1) >>> f equals -((|v| + half) >> f).
	function automatic logic signed [COORD_W-1:0] round_sat(
		input logic signed [RND_W-1:0] v,
		input int unsigned f
	);
		logic signed [RND_W-1:0] half;
		logic signed [RND_W-1:0] adj;
		logic signed [RND_W-1:0] r;
		half = RND_W'(64'sd1 <<< (f - 1));
		adj  = v[RND_W-1] ? (half - RND_W'(64'sd1)) : half;
		r    = (v + adj) >>> f;
		if (r > RND_W'(64'sd2147483647)) begin
			round_sat = {1'b0, {(COORD_W-1){1'b1}}};
		end else if (r < -RND_W'(64'sd2147483648)) begin
			round_sat = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			round_sat = r[COORD_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// File: rtl/grid_point_three_axis_rotation_core.sv
// Top level of the grid point rotation core: config registers and rotation pipeline.
`default_nettype none

// Scales a centered grid point (column, row, height) by zoom and height gain, then
// rotates it about x, y and z, rounding half away from zero and saturating to 32 bits
// after each rotation. Accepts one point per clock while point_stall is low and returns
// one result per point, in order. Each rotation takes three stages (multiply, sum,
// round/saturate) after one scaling stage, and the last stage is the output register.
// Valid bits move with the data and empty stages close up, so a stalled output holds new
// requests only once all ten stages are full. Sines and cosines are Q2.14, height gain
// Q9.8; write them through the APB port only while no request is in flight.
module grid_point_three_axis_rotation_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// point requests
	input  wire                                 point_valid,
	output logic                                point_stall,
	input  gp3rot_pkg::point_t                  point,
	// results
	output logic                                result_valid,
	input  wire                                 result_stall,
	output gp3rot_pkg::result_t                 result,
	// configuration
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [gp3rot_pkg::PADDR_W-1:0]      paddr,
	input  wire  [gp3rot_pkg::PDATA_W-1:0]      pwdata,
	output logic [gp3rot_pkg::PDATA_W-1:0]      prdata,
	output logic                                pready
);

	localparam int unsigned NSTG = 10;

	localparam int unsigned T  = gp3rot_pkg::TRIG_FRAC_BITS;
	localparam int unsigned G  = gp3rot_pkg::GAIN_FRAC_BITS;
	localparam int unsigned TW = gp3rot_pkg::TRIG_W;
	localparam int unsigned CW = gp3rot_pkg::COORD_W;
	localparam int unsigned OW = gp3rot_pkg::OFS_W;
	localparam int unsigned HW = gp3rot_pkg::HGT_W;
	localparam int unsigned BW = gp3rot_pkg::BT_P_W;
	localparam int unsigned HPW = gp3rot_pkg::HT_P_W;
	localparam int unsigned SXW = gp3rot_pkg::RX_S_W;
	localparam int unsigned APW = gp3rot_pkg::AT_P_W;
	localparam int unsigned CPW = gp3rot_pkg::CT_P_W;
	localparam int unsigned SYW = gp3rot_pkg::RYZ_S_W;
	localparam int unsigned RW = gp3rot_pkg::RND_W;

	// ---------------------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------------------
	logic signed [TW-1:0]                   cos_x_q, sin_x_q;
	logic signed [TW-1:0]                   cos_y_q, sin_y_q;
	logic signed [TW-1:0]                   cos_z_q, sin_z_q;
	logic [gp3rot_pkg::ZOOM_W-1:0]          zoom_q;
	logic signed [gp3rot_pkg::GAIN_W-1:0]   gain_q;
	gp3rot_pkg::reg_idx_t                   reg_idx;
	logic                                   cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = gp3rot_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_x_q <= gp3rot_pkg::TRIG_ONE;
			sin_x_q <= gp3rot_pkg::TRIG_ZERO;
			cos_y_q <= gp3rot_pkg::TRIG_ONE;
			sin_y_q <= gp3rot_pkg::TRIG_ZERO;
			cos_z_q <= gp3rot_pkg::TRIG_ONE;
			sin_z_q <= gp3rot_pkg::TRIG_ZERO;
			zoom_q  <= gp3rot_pkg::ZOOM_RESET;
			gain_q  <= gp3rot_pkg::GAIN_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				gp3rot_pkg::REG_COS_X: cos_x_q <= pwdata[TW-1:0];
				gp3rot_pkg::REG_SIN_X: sin_x_q <= pwdata[TW-1:0];
				gp3rot_pkg::REG_COS_Y: cos_y_q <= pwdata[TW-1:0];
				gp3rot_pkg::REG_SIN_Y: sin_y_q <= pwdata[TW-1:0];
				gp3rot_pkg::REG_COS_Z: cos_z_q <= pwdata[TW-1:0];
				gp3rot_pkg::REG_SIN_Z: sin_z_q <= pwdata[TW-1:0];
				gp3rot_pkg::REG_ZOOM:  zoom_q  <= pwdata[gp3rot_pkg::ZOOM_W-1:0];
				gp3rot_pkg::REG_GAIN:  gain_q  <= pwdata[gp3rot_pkg::GAIN_W-1:0];
			endcase
		end
	end

	// Readback, signed registers sign-extended
	always_comb begin
		unique case (reg_idx)
			gp3rot_pkg::REG_COS_X: prdata = gp3rot_pkg::PDATA_W'(cos_x_q);
			gp3rot_pkg::REG_SIN_X: prdata = gp3rot_pkg::PDATA_W'(sin_x_q);
			gp3rot_pkg::REG_COS_Y: prdata = gp3rot_pkg::PDATA_W'(cos_y_q);
			gp3rot_pkg::REG_SIN_Y: prdata = gp3rot_pkg::PDATA_W'(sin_y_q);
			gp3rot_pkg::REG_COS_Z: prdata = gp3rot_pkg::PDATA_W'(cos_z_q);
			gp3rot_pkg::REG_SIN_Z: prdata = gp3rot_pkg::PDATA_W'(sin_z_q);
			gp3rot_pkg::REG_ZOOM:  prdata = gp3rot_pkg::PDATA_W'(zoom_q);
			gp3rot_pkg::REG_GAIN:  prdata = gp3rot_pkg::PDATA_W'(gain_q);
		endcase
	end

	// ---------------------------------------------------------------------------------
	// Pipeline control: a stage loads when it is empty or its successor loads
	// ---------------------------------------------------------------------------------
	logic [NSTG:1]   vld_q;
	logic [NSTG+1:1] adv;
	logic [NSTG:1]   vld_in;

	assign adv[NSTG+1] = !result_stall;
	assign vld_in      = {vld_q[NSTG-1:1], point_valid};

	for (genvar k = 1; k <= NSTG; k++) begin : g_ctl
		assign adv[k] = !vld_q[k] || adv[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_q[k] <= vld_in[k];
			end
		end
	end

	assign point_stall  = !adv[1];
	assign result_valid = vld_q[NSTG];

	// ---------------------------------------------------------------------------------
	// Stage 1: scale offsets by zoom and height by gain
	// ---------------------------------------------------------------------------------
	logic signed [OW:0]   a_full, b_full;
	logic signed [HW-1:0] h_full;
	logic signed [OW-1:0] a_s1, b_s1;
	logic signed [HW-1:0] h_s1;

	assign a_full = (OW + 1)'(point.column_offset) * $signed({1'b0, zoom_q});
	assign b_full = (OW + 1)'(point.row_offset) * $signed({1'b0, zoom_q});
	assign h_full = HW'(point.point_height) * HW'(gain_q);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			a_s1 <= a_full[OW-1:0];
			b_s1 <= b_full[OW-1:0];
			h_s1 <= h_full;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 2: products for the rotation about x
	// ---------------------------------------------------------------------------------
	logic signed [BW-1:0]  p_bcx_s2, p_bsx_s2;
	logic signed [HPW-1:0] p_hsx_s2, p_hcx_s2;
	logic signed [OW-1:0]  a_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			p_bcx_s2 <= BW'(b_s1) * BW'(cos_x_q);
			p_bsx_s2 <= BW'(b_s1) * BW'(sin_x_q);
			p_hsx_s2 <= HPW'(h_s1) * HPW'(sin_x_q);
			p_hcx_s2 <= HPW'(h_s1) * HPW'(cos_x_q);
			a_s2     <= a_s1;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 3: sums for the rotation about x (row term aligned to the gain fraction)
	// ---------------------------------------------------------------------------------
	logic signed [SXW-1:0] y1_sum_s3, z1_sum_s3;
	logic signed [OW-1:0]  a_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			y1_sum_s3 <= (SXW'(p_bcx_s2) <<< G) - SXW'(p_hsx_s2);
			z1_sum_s3 <= (SXW'(p_bsx_s2) <<< G) + SXW'(p_hcx_s2);
			a_s3      <= a_s2;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 4: round and saturate y1, z1
	// ---------------------------------------------------------------------------------
	logic signed [CW-1:0] y1_s4, z1_s4;
	logic signed [OW-1:0] a_s4;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			y1_s4 <= gp3rot_pkg::round_sat(RW'(y1_sum_s3), gp3rot_pkg::RX_FRAC);
			z1_s4 <= gp3rot_pkg::round_sat(RW'(z1_sum_s3), gp3rot_pkg::RX_FRAC);
			a_s4  <= a_s3;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 5: products for the rotation about y
	// ---------------------------------------------------------------------------------
	logic signed [APW-1:0] p_acy_s5, p_asy_s5;
	logic signed [CPW-1:0] p_zsy_s5, p_zcy_s5;
	logic signed [CW-1:0]  y1_s5;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			p_acy_s5 <= APW'(a_s4) * APW'(cos_y_q);
			p_asy_s5 <= APW'(a_s4) * APW'(sin_y_q);
			p_zsy_s5 <= CPW'(z1_s4) * CPW'(sin_y_q);
			p_zcy_s5 <= CPW'(z1_s4) * CPW'(cos_y_q);
			y1_s5    <= y1_s4;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 6: sums for the rotation about y
	// ---------------------------------------------------------------------------------
	logic signed [SYW-1:0] x2_sum_s6, z2_sum_s6;
	logic signed [CW-1:0]  y1_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			x2_sum_s6 <= SYW'(p_acy_s5) + SYW'(p_zsy_s5);
			z2_sum_s6 <= SYW'(p_zcy_s5) - SYW'(p_asy_s5);
			y1_s6     <= y1_s5;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 7: round and saturate x2, z2
	// ---------------------------------------------------------------------------------
	logic signed [CW-1:0] x2_s7, z2_s7, y1_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			x2_s7 <= gp3rot_pkg::round_sat(RW'(x2_sum_s6), T);
			z2_s7 <= gp3rot_pkg::round_sat(RW'(z2_sum_s6), T);
			y1_s7 <= y1_s6;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 8: products for the rotation about z
	// ---------------------------------------------------------------------------------
	logic signed [CPW-1:0] p_xcz_s8, p_ysz_s8, p_xsz_s8, p_ycz_s8;
	logic signed [CW-1:0]  z2_s8;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			p_xcz_s8 <= CPW'(x2_s7) * CPW'(cos_z_q);
			p_ysz_s8 <= CPW'(y1_s7) * CPW'(sin_z_q);
			p_xsz_s8 <= CPW'(x2_s7) * CPW'(sin_z_q);
			p_ycz_s8 <= CPW'(y1_s7) * CPW'(cos_z_q);
			z2_s8    <= z2_s7;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 9: sums for the rotation about z
	// ---------------------------------------------------------------------------------
	logic signed [SYW-1:0] x3_sum_s9, y3_sum_s9;
	logic signed [CW-1:0]  z2_s9;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			x3_sum_s9 <= SYW'(p_xcz_s8) - SYW'(p_ysz_s8);
			y3_sum_s9 <= SYW'(p_xsz_s8) + SYW'(p_ycz_s8);
			z2_s9     <= z2_s8;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 10: round and saturate x3, y3 into the output register
	// ---------------------------------------------------------------------------------
	gp3rot_pkg::result_t res_s10;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			res_s10.rotated_x <= gp3rot_pkg::round_sat(RW'(x3_sum_s9), T);
			res_s10.rotated_y <= gp3rot_pkg::round_sat(RW'(y3_sum_s9), T);
			res_s10.rotated_z <= z2_s9;
		end
	end

	assign result = res_s10;

	// ---------------------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------------------
	// New requests are held off only when every stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		point_stall |-> (&vld_q))
		else $error("request stalled while pipeline has an empty stage");

	// A free output never backs up into the input
	a_no_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_stall |-> !point_stall)
		else $error("input stalled while output is free");

	// A blocked mid-pipeline stage keeps its item
	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[4] && !adv[4] |=> vld_q[4] && $stable(y1_s4) && $stable(z1_s4))
		else $error("stage 4 lost or changed a held item");

	// Occupancy drops by at most one per cycle
	a_drain_rate: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones(vld_q) + 1 >= $past($countones(vld_q))))
		else $error("more than one item left the pipeline in a cycle");

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the grid point three-axis rotation core.
`timescale 1ns / 100ps

module tb;

	localparam int QUIET_LIMIT   = 400;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_POINTS  = 128;
	localparam int DRAIN_CYCLES  = 24;
	localparam int SHOW_LIMIT    = 10;
	localparam longint COORD_MAX = 64'sd2147483647;
	localparam longint COORD_MIN = -64'sd2147483648;

	// Register settings used by the directed table and the random phases
	typedef enum logic [2:0] {
		SET_RESET,
		SET_HALF_COS_X,
		SET_NEG_FULL,
		SET_POS_FULL,
		SET_ZERO_ZOOM,
		SET_QUARTER_TURNS,
		SET_RANDOM
	} setting_t;

	typedef struct packed {
		setting_t             setting;
		logic                 known;
		gp3rot_pkg::point_t   pt;
		gp3rot_pkg::result_t  want;
	} table_row_t;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               point_valid;
	logic                               point_stall;
	gp3rot_pkg::point_t                 point;
	logic                               result_valid;
	logic                               result_stall = 1'b0;
	gp3rot_pkg::result_t                result;
	logic                               psel;
	logic                               penable;
	logic                               pwrite;
	logic [gp3rot_pkg::PADDR_W-1:0]     paddr;
	logic [gp3rot_pkg::PDATA_W-1:0]     pwdata;
	logic [gp3rot_pkg::PDATA_W-1:0]     prdata;
	logic                               pready;

	// Shadow copy of the configuration registers
	logic signed [gp3rot_pkg::TRIG_W-1:0] trig_now [0:5];
	logic [gp3rot_pkg::ZOOM_W-1:0]        zoom_now;
	logic signed [gp3rot_pkg::GAIN_W-1:0] gain_now;

	gp3rot_pkg::result_t  pending_rotations [$];
	table_row_t           table_rows [$];
	logic [31:0]          reg_plan [0:7];
	int                   error_count  = 0;
	int                   stall_left   = 0;
	int                   quiet_cycles = 0;
	bit                   idle_on      = 1'b1;

	grid_point_three_axis_rotation_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_stall  (point_stall),
		.point        (point),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Round half away from zero with f fraction bits, clamp to 32 bits signed
	function automatic longint round_to_coord(input longint v, input int unsigned f);
		longint half;
		longint m;
		half = 64'sd1 <<< (f - 1);
		if (v >= 0)
			m = (v + half) >>> f;
		else
			m = -((-v + half) >>> f);
		if (m > COORD_MAX)
			m = COORD_MAX;
		else if (m < COORD_MIN)
			m = COORD_MIN;
		return m;
	endfunction

	// Scale the point, then rotate about x, y and z with the shadow registers
	function automatic gp3rot_pkg::result_t rotate_point(input gp3rot_pkg::point_t p);
		longint a, b, h, bq;
		longint cx, sx, cy, sy, cz, sz;
		longint y1, z1, x2, z2, x3, y3;
		gp3rot_pkg::result_t r;
		cx = trig_now[gp3rot_pkg::REG_COS_X];
		sx = trig_now[gp3rot_pkg::REG_SIN_X];
		cy = trig_now[gp3rot_pkg::REG_COS_Y];
		sy = trig_now[gp3rot_pkg::REG_SIN_Y];
		cz = trig_now[gp3rot_pkg::REG_COS_Z];
		sz = trig_now[gp3rot_pkg::REG_SIN_Z];
		a  = longint'($signed(p.column_offset)) * longint'(zoom_now);
		b  = longint'($signed(p.row_offset)) * longint'(zoom_now);
		h  = longint'($signed(p.point_height)) * longint'(gain_now);
		bq = b <<< gp3rot_pkg::GAIN_FRAC_BITS;
		// about x: the row offset carries the gain fraction too
		y1 = round_to_coord(bq * cx - h * sx,
			gp3rot_pkg::TRIG_FRAC_BITS + gp3rot_pkg::GAIN_FRAC_BITS);
		z1 = round_to_coord(bq * sx + h * cx,
			gp3rot_pkg::TRIG_FRAC_BITS + gp3rot_pkg::GAIN_FRAC_BITS);
		// about y
		x2 = round_to_coord(a * cy + z1 * sy, gp3rot_pkg::TRIG_FRAC_BITS);
		z2 = round_to_coord(z1 * cy - a * sy, gp3rot_pkg::TRIG_FRAC_BITS);
		// about z
		x3 = round_to_coord(x2 * cz - y1 * sz, gp3rot_pkg::TRIG_FRAC_BITS);
		y3 = round_to_coord(x2 * sz + y1 * cz, gp3rot_pkg::TRIG_FRAC_BITS);
		r.rotated_x = x3[gp3rot_pkg::COORD_W-1:0];
		r.rotated_y = y3[gp3rot_pkg::COORD_W-1:0];
		r.rotated_z = z2[gp3rot_pkg::COORD_W-1:0];
		return r;
	endfunction

	function automatic void apply_register(input gp3rot_pkg::reg_idx_t idx,
			input logic [31:0] v);
		case (idx)
			gp3rot_pkg::REG_ZOOM: zoom_now = v[gp3rot_pkg::ZOOM_W-1:0];
			gp3rot_pkg::REG_GAIN: gain_now = v[gp3rot_pkg::GAIN_W-1:0];
			default:              trig_now[idx] = v[gp3rot_pkg::TRIG_W-1:0];
		endcase
	endfunction

	// Full-range fields, with the extremes drawn now and then
	function automatic gp3rot_pkg::point_t random_point();
		gp3rot_pkg::point_t p;
		p.column_offset = gp3rot_pkg::OFS_IN_W'($urandom);
		p.row_offset    = gp3rot_pkg::OFS_IN_W'($urandom);
		p.point_height  = gp3rot_pkg::HGT_IN_W'($urandom);
		if ($urandom_range(0, 7) == 0)
			p.column_offset = $urandom_range(0, 1) ? 12'sh7FF : 12'sh800;
		if ($urandom_range(0, 7) == 0)
			p.row_offset = $urandom_range(0, 1) ? 12'sh7FF : 12'sh800;
		if ($urandom_range(0, 7) == 0)
			p.point_height = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		return p;
	endfunction

	task automatic add_row(input setting_t s, input logic known,
			input int c, input int r, input int ht, input int wx, input int wy, input int wz);
		table_row_t row;
		row.setting          = s;
		row.known            = known;
		row.pt.column_offset = gp3rot_pkg::OFS_IN_W'(c);
		row.pt.row_offset    = gp3rot_pkg::OFS_IN_W'(r);
		row.pt.point_height  = gp3rot_pkg::HGT_IN_W'(ht);
		row.want.rotated_x   = gp3rot_pkg::COORD_W'(wx);
		row.want.rotated_y   = gp3rot_pkg::COORD_W'(wy);
		row.want.rotated_z   = gp3rot_pkg::COORD_W'(wz);
		table_rows.push_back(row);
	endtask

	// One APB write: setup cycle, then access cycle
	task automatic apb_write(input gp3rot_pkg::reg_idx_t idx, input logic [31:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		apply_register(idx, v);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Stop sending and wait for every outstanding result
	task automatic settle_pipeline();
		@(negedge clk);
		point_valid <= 1'b0;
		while (pending_rotations.size() != 0)
			@(posedge clk);
	endtask

	// Write all eight registers once the pipeline is empty; unused upper bits get junk
	task automatic commit_plan();
		int w;
		logic [31:0] mask;
		settle_pipeline();
		for (int i = 0; i < 8; i++) begin
			w = (i == gp3rot_pkg::REG_ZOOM) ? gp3rot_pkg::ZOOM_W :
				(i == gp3rot_pkg::REG_GAIN) ? gp3rot_pkg::GAIN_W : gp3rot_pkg::TRIG_W;
			mask = (32'd1 << w) - 32'd1;
			apb_write(gp3rot_pkg::reg_idx_t'(i), (reg_plan[i] & mask) | ($urandom & ~mask));
		end
	endtask

	task automatic program_setting(input setting_t s);
		// start from the reset values
		for (int i = 0; i < 6; i++)
			reg_plan[i] = (i % 2 == 0) ? 32'd16384 : 32'd0;
		reg_plan[gp3rot_pkg::REG_ZOOM] = 32'd1;
		reg_plan[gp3rot_pkg::REG_GAIN] = 32'd256;
		case (s)
			SET_HALF_COS_X: begin
				reg_plan[gp3rot_pkg::REG_COS_X] = 32'd8192;
			end
			SET_NEG_FULL: begin
				for (int i = 0; i < 6; i++)
					reg_plan[i] = 32'hFFFF_8000;
				reg_plan[gp3rot_pkg::REG_ZOOM] = 32'd255;
				reg_plan[gp3rot_pkg::REG_GAIN] = 32'hFFFF_0000;
			end
			SET_POS_FULL: begin
				for (int i = 0; i < 6; i++)
					reg_plan[i] = 32'h0000_7FFF;
				reg_plan[gp3rot_pkg::REG_ZOOM] = 32'd255;
				reg_plan[gp3rot_pkg::REG_GAIN] = 32'h0000_FFFF;
			end
			SET_ZERO_ZOOM: begin
				for (int i = 0; i < 6; i++)
					reg_plan[i] = $urandom;
				reg_plan[gp3rot_pkg::REG_ZOOM] = 32'd0;
				reg_plan[gp3rot_pkg::REG_GAIN] = 32'hFFFF_0000;
			end
			SET_QUARTER_TURNS: begin
				// each trig value is one of -1.0, 0, +1.0
				for (int i = 0; i < 6; i++)
					reg_plan[i] = 32'($urandom_range(0, 2) * 16384) - 32'd16384;
				reg_plan[gp3rot_pkg::REG_ZOOM] = 32'd255;
				reg_plan[gp3rot_pkg::REG_GAIN] = 32'hFFFF_0000;
			end
			SET_RANDOM: begin
				// half the time within +-1.0, else the full 16-bit range
				for (int i = 0; i < 6; i++)
					reg_plan[i] = $urandom_range(0, 1) ?
						32'($urandom_range(0, 32768)) - 32'd16384 : $urandom;
				reg_plan[gp3rot_pkg::REG_ZOOM] = $urandom_range(0, 255);
				reg_plan[gp3rot_pkg::REG_GAIN] = $urandom;
			end
			default: ;
		endcase
		commit_plan();
	endtask

	// Drive one request after a random gap while idle_on is set, hold it until accepted
	task automatic send_point(input gp3rot_pkg::point_t p, input logic known,
			input gp3rot_pkg::result_t want);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			@(negedge clk);
			point_valid <= 1'b0;
		end
		@(negedge clk);
		point_valid <= 1'b1;
		point       <= p;
		@(posedge clk);
		while (point_stall)
			@(posedge clk);
		pending_rotations.push_back(known ? want : rotate_point(p));
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			error_count++;
			if (error_count <= SHOW_LIMIT)
				$display("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
		end
	endtask

	// Result side: check each accepted result, then draw the next stall
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_rotations.size() == 0) begin
				error_count++;
				if (error_count <= SHOW_LIMIT)
					$display("unexpected result: x %0d y %0d z %0d", result.rotated_x,
						result.rotated_y, result.rotated_z);
			end else begin
				check_field("rotated_x", pending_rotations[0].rotated_x, result.rotated_x);
				check_field("rotated_y", pending_rotations[0].rotated_y, result.rotated_y);
				check_field("rotated_z", pending_rotations[0].rotated_z, result.rotated_z);
				void'(pending_rotations.pop_front());
			end
			stall_left = idle_on ? $urandom_range(0, 3) : 0;
		end
	end

	always @(negedge clk) begin
		result_stall <= (stall_left > 0);
		if (stall_left > 0)
			stall_left--;
	end

	// Watchdog: cycles with no handshake on any port
	always @(posedge clk) begin
		if (!arst_n || (point_valid && !point_stall) || (result_valid && !result_stall) ||
				(psel && penable && pwrite && pready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("grid_point_three_axis_rotation_core regression: fail");
				$finish;
			end
		end
	end

	initial begin
		setting_t current;
		arst_n      = 1'b0;
		point_valid = 1'b0;
		point       = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		for (int i = 0; i < 6; i++)
			trig_now[i] = (i % 2 == 0) ? gp3rot_pkg::TRIG_ONE : gp3rot_pkg::TRIG_ZERO;
		zoom_now = gp3rot_pkg::ZOOM_RESET;
		gain_now = gp3rot_pkg::GAIN_RESET;

		// Reset registers give the identity: output equals (column, row, height)
		add_row(SET_RESET, 1'b1, 0, 0, 0, 0, 0, 0);
		add_row(SET_RESET, 1'b1, 2047, 2047, 32767, 2047, 2047, 32767);
		add_row(SET_RESET, 1'b1, -2048, -2048, -32768, -2048, -2048, -32768);
		add_row(SET_RESET, 1'b1, 2047, -2048, 32767, 2047, -2048, 32767);
		add_row(SET_RESET, 1'b1, -2048, 2047, -32768, -2048, 2047, -32768);
		add_row(SET_RESET, 1'b1, 1, -1, 1, 1, -1, 1);
		add_row(SET_RESET, 1'b1, -1, 1, -1, -1, 1, -1);
		add_row(SET_RESET, 1'b1, 1365, -1366, 21845, 1365, -1366, 21845);
		add_row(SET_RESET, 1'b1, -1366, 1365, -21846, -1366, 1365, -21846);
		// cos about x = 0.5 halves row and height: ties round away from zero
		add_row(SET_HALF_COS_X, 1'b1, 0, 1, 1, 0, 1, 1);
		add_row(SET_HALF_COS_X, 1'b1, 0, -1, -1, 0, -1, -1);
		add_row(SET_HALF_COS_X, 1'b1, 5, 3, -3, 5, 2, -2);
		add_row(SET_HALF_COS_X, 1'b1, -5, -3, 3, -5, -2, 2);
		add_row(SET_HALF_COS_X, 1'b1, 7, 4, 6, 7, 2, 3);
		add_row(SET_HALF_COS_X, 1'b1, 2047, 2047, 32767, 2047, 1024, 16384);
		add_row(SET_HALF_COS_X, 1'b1, -2048, -2048, -32768, -2048, -1024, -16384);
		// trig at -2.0 everywhere, largest zoom and most negative gain
		add_row(SET_NEG_FULL, 1'b0, 2047, 2047, 32767, 0, 0, 0);
		add_row(SET_NEG_FULL, 1'b0, -2048, -2048, -32768, 0, 0, 0);
		add_row(SET_NEG_FULL, 1'b0, 2047, -2048, -32768, 0, 0, 0);
		add_row(SET_NEG_FULL, 1'b0, -1, 1, 1, 0, 0, 0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table
		current = SET_RESET;
		foreach (table_rows[i]) begin
			if (table_rows[i].setting != current) begin
				current = table_rows[i].setting;
				program_setting(current);
			end
			send_point(table_rows[i].pt, table_rows[i].known, table_rows[i].want);
		end

		// Random phases, extremes of the registers first
		for (int n = 0; n < RANDOM_PHASES; n++) begin
			case (n)
				0:       program_setting(SET_POS_FULL);
				1:       program_setting(SET_ZERO_ZOOM);
				2:       program_setting(SET_QUARTER_TURNS);
				3:       program_setting(SET_NEG_FULL);
				default: program_setting(SET_RANDOM);
			endcase
			idle_on = (n != 3) && ($urandom_range(0, 3) != 0);
			repeat (PHASE_POINTS)
				send_point(random_point(), 1'b0, '0);
		end

		settle_pipeline();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("grid_point_three_axis_rotation_core regression: pass");
		else
			$display("grid_point_three_axis_rotation_core regression: fail");
		$finish;
	end

endmodule

// File: filelist.f
rtl/gp3rot_pkg.sv
rtl/grid_point_three_axis_rotation_core.sv
dv/tb.sv
